[hw/rtl/bol_pkg.sv]
package bol_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    localparam int ACTION_BITS   = 3;
    localparam int POSITION_BITS = 4;
    localparam int CAP_BITS      = 5;
    localparam int ENTRY_BITS    = 5;

    localparam logic [ACTION_BITS-1:0] ACT_PREPEND    = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_APPEND     = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ_POS   = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE_VAL = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE_POS = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_CONTAINS   = 3'd5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [ACTION_BITS-1:0]   action;
        logic [VALUE_BITS-1:0]    item_value;
        logic [POSITION_BITS-1:0] position;
    } in_item_t;

    typedef struct packed {
        logic                  ok;
        logic [VALUE_BITS-1:0] value_out;
        logic [ENTRY_BITS-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic                 take;
        logic                 release_en;
        logic [SLOT_BITS-1:0] release_slot;
    } free_cmd_t;

endpackage

[hw/rtl/bounded_ordered_list_engine_unit.sv]
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | in_item (action, item_value, position)
// out     | output    | out_valid/out_stall | out_item (ok, value_out, entry_count)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (capacity)
//
// Prepend/append pass through dispatch, then the tail link step for an accepted
// append to a non-empty list, then done; read, remove and contains walk up to 16
// entries, one entry per cycle through the registered read of the slot memories.
// The input is stalled from accept until the result is loaded into the output
// register; a pending result does not block the next accept.
// Reset leaves the list empty, all slots free and capacity at 16.
module bounded_ordered_list_engine_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bol_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bol_pkg::out_item_t           out_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bol_pkg::CAP_BITS-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_DISPATCH    = 3'd1;
    localparam logic [2:0] ST_APPEND_LINK = 3'd2;
    localparam logic [2:0] ST_WALK        = 3'd3;
    localparam logic [2:0] ST_DONE        = 3'd4;

    localparam int SB = bol_pkg::SLOT_BITS;
    localparam int CB = bol_pkg::COUNT_BITS;
    localparam int VB = bol_pkg::VALUE_BITS;

    logic [2:0]                          state_reg, state_next;
    logic [bol_pkg::ACTION_BITS-1:0]     act_reg, act_next;
    logic [VB-1:0]                       val_reg, val_next;
    logic [bol_pkg::POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [SB-1:0]                       head_reg, head_next;
    logic [SB-1:0]                       tail_reg, tail_next;
    logic [CB-1:0]                       count_reg, count_next;
    logic [bol_pkg::CAP_BITS-1:0]        cap_reg, cap_next;
    logic [SB-1:0]                       cur_reg, cur_next;
    logic [SB-1:0]                       prev_reg, prev_next;
    logic                                prev_none_reg, prev_none_next;
    logic [SB-1:0]                       idx_reg, idx_next;
    logic [SB-1:0]                       new_slot_reg, new_slot_next;
    logic                                ok_reg, ok_next;
    logic [VB-1:0]                       vout_reg, vout_next;
    logic                                out_valid_reg, out_valid_next;
    bol_pkg::out_item_t                  out_item_reg, out_item_next;

    logic                                val_we;
    logic [SB-1:0]                       val_waddr;
    logic                                link_we;
    logic [SB-1:0]                       link_waddr;
    logic [SB-1:0]                       link_wdata;
    logic                                rd_en;
    logic [SB-1:0]                       rd_addr;
    logic [VB-1:0]                       val_rd;
    logic [SB-1:0]                       link_rd;

    bol_pkg::free_cmd_t                  free_cmd;
    logic [SB-1:0]                       lowest_slot;
    logic [bol_pkg::DEPTH-1:0]           free_map;

    logic [CB-1:0]                       limit;
    logic                                by_pos;
    logic                                match;
    logic                                last;
    logic                                is_remove;
    logic [CB-1:0]                       count_dec;

    bol_ram #(
        .WIDTH (VB),
        .DEPTH (bol_pkg::DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rd)
    );

    bol_ram #(
        .WIDTH (SB),
        .DEPTH (bol_pkg::DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    bol_free_map u_free_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (free_cmd),
        .lowest_slot (lowest_slot),
        .free_map    (free_map)
    );

    assign limit = (cap_reg >= bol_pkg::CAP_BITS'(bol_pkg::DEPTH)) ?
                   CB'(bol_pkg::DEPTH) : CB'(cap_reg);
    assign by_pos    = (act_reg == bol_pkg::ACT_READ_POS) ||
                       (act_reg == bol_pkg::ACT_REMOVE_POS);
    assign match     = by_pos ? (32'(idx_reg) == 32'(pos_reg)) : (val_rd == val_reg);
    assign last      = ((CB'(idx_reg) + CB'(1)) == count_reg);
    assign is_remove = (act_reg == bol_pkg::ACT_REMOVE_VAL) ||
                       (act_reg == bol_pkg::ACT_REMOVE_POS);
    assign count_dec = count_reg - CB'(1);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_none_next = prev_none_reg;
        idx_next       = idx_reg;
        new_slot_next  = new_slot_reg;
        ok_next        = ok_reg;
        vout_next      = vout_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        val_we         = 1'b0;
        val_waddr      = lowest_slot;
        link_we        = 1'b0;
        link_waddr     = lowest_slot;
        link_wdata     = '0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        free_cmd       = '0;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = in_item.action;
                    val_next   = in_item.item_value;
                    pos_next   = in_item.position;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                ok_next    = 1'b0;
                vout_next  = '0;
                state_next = ST_DONE;
                case (act_reg)
                    bol_pkg::ACT_PREPEND, bol_pkg::ACT_APPEND:
                    begin
                        if (count_reg < limit)
                        begin
                            val_we        = 1'b1;
                            link_we       = 1'b1;
                            free_cmd.take = 1'b1;
                            count_next    = count_reg + CB'(1);
                            ok_next       = 1'b1;
                            if (count_reg == '0)
                            begin
                                head_next = lowest_slot;
                                tail_next = lowest_slot;
                            end
                            else if (act_reg == bol_pkg::ACT_PREPEND)
                            begin
                                link_wdata = head_reg;
                                head_next  = lowest_slot;
                            end
                            else
                            begin
                                new_slot_next = lowest_slot;
                                state_next    = ST_APPEND_LINK;
                            end
                        end
                    end
                    bol_pkg::ACT_READ_POS, bol_pkg::ACT_REMOVE_VAL,
                    bol_pkg::ACT_REMOVE_POS, bol_pkg::ACT_CONTAINS:
                    begin
                        if (count_reg != '0)
                        begin
                            rd_en          = 1'b1;
                            rd_addr        = head_reg;
                            cur_next       = head_reg;
                            prev_none_next = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_APPEND_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = new_slot_reg;
                tail_next  = new_slot_reg;
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (match)
                begin
                    ok_next    = 1'b1;
                    vout_next  = (act_reg == bol_pkg::ACT_CONTAINS) ? '0 : val_rd;
                    state_next = ST_DONE;
                    if (is_remove)
                    begin
                        free_cmd.release_en   = 1'b1;
                        free_cmd.release_slot = cur_reg;
                        count_next            = count_dec;
                        if (prev_none_reg)
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = link_rd;
                        end
                        if ((cur_reg == tail_reg) && !prev_none_reg)
                        begin
                            tail_next = prev_reg;
                        end
                        if (count_dec == '0)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
                else if (last)
                begin
                    ok_next    = 1'b0;
                    vout_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    // advance to the next linked entry
                    rd_en          = 1'b1;
                    rd_addr        = link_rd;
                    prev_next      = cur_reg;
                    prev_none_next = 1'b0;
                    cur_next       = link_rd;
                    idx_next       = idx_reg + SB'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next.ok          = ok_reg;
                    out_item_next.value_out   = vout_reg;
                    out_item_next.entry_count = bol_pkg::ENTRY_BITS'(count_reg);
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= bol_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_none_reg <= prev_none_next;
        idx_reg       <= idx_next;
        new_slot_reg  <= new_slot_next;
        ok_reg        <= ok_next;
        vout_reg      <= vout_next;
        out_item_reg  <= out_item_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(bol_pkg::DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(free_map) + 32'(count_reg)) == bol_pkg::DEPTH)
        else $error("free map disagrees with entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (CB'(idx_reg) < count_reg))
        else $error("walk ran past the last entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPATCH) |=> (state_reg != ST_IDLE))
        else $error("item finished without a result");
`endif

endmodule

[hw/rtl/bol_ram.sv]
module bol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/bol_free_map.sv]
module bol_free_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bol_pkg::free_cmd_t            cmd,
    output logic [bol_pkg::SLOT_BITS-1:0] lowest_slot,
    output logic [bol_pkg::DEPTH-1:0]     free_map
);

    logic [bol_pkg::DEPTH-1:0] free_reg;
    logic [bol_pkg::DEPTH-1:0] free_next;

    // pick the lowest free slot
    always_comb
    begin
        lowest_slot = '0;
        for (int s = bol_pkg::DEPTH - 1; s >= 0; s--)
        begin
            if (free_reg[s])
            begin
                lowest_slot = bol_pkg::SLOT_BITS'(s);
            end
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (cmd.take)
        begin
            free_next[lowest_slot] = 1'b0;
        end
        if (cmd.release_en)
        begin
            free_next[cmd.release_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

    assign free_map = free_reg;

endmodule

[bench/bounded_ordered_list_engine_unit_tb.sv]
`timescale 1ns / 1ps

module bounded_ordered_list_engine_unit_tb;

    import bol_pkg::*;

    localparam logic [ACTION_BITS-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_B = 3'd7;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int BURST_ITEMS = 30;
    localparam int POOL_SIZE   = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic      typed;
        out_item_t want;
        in_item_t  req;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_stall;
    out_item_t           out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data;

    logic [VALUE_BITS-1:0] held [$];
    logic [CAP_BITS-1:0]   cap_now;
    out_item_t             pending_results [$];
    out_item_t             want_now;
    logic [VALUE_BITS-1:0] pool [POOL_SIZE];
    script_row_t           script [$];
    int                    mismatches;
    bit                    quiet;
    bit                    hold_go;
    bit                    hold_on;

    bounded_ordered_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic out_item_t apply_request(in_item_t req);
        out_item_t r;
        int        lim;
        int        hit;
        int        i;
        r   = '0;
        lim = (int'(cap_now) < DEPTH) ? int'(cap_now) : DEPTH;
        hit = -1;
        case (req.action)
            ACT_PREPEND, ACT_APPEND:
            begin
                if (held.size() < lim)
                begin
                    if (req.action == ACT_PREPEND)
                        held.push_front(req.item_value);
                    else
                        held.push_back(req.item_value);
                    r.ok = 1'b1;
                end
            end
            ACT_READ_POS:
            begin
                if (int'(req.position) < held.size())
                begin
                    r.ok        = 1'b1;
                    r.value_out = held[req.position];
                end
            end
            ACT_REMOVE_POS:
            begin
                if (int'(req.position) < held.size())
                begin
                    r.ok        = 1'b1;
                    r.value_out = held[req.position];
                    held.delete(req.position);
                end
            end
            ACT_REMOVE_VAL, ACT_CONTAINS:
            begin
                for (i = 0; i < held.size() && hit < 0; i++)
                    if (held[i] == req.item_value)
                        hit = i;
                if (hit >= 0)
                begin
                    r.ok = 1'b1;
                    if (req.action == ACT_REMOVE_VAL)
                    begin
                        r.value_out = held[hit];
                        held.delete(hit);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = ENTRY_BITS'(held.size());
        return r;
    endfunction

    function automatic script_row_t mk(logic [ACTION_BITS-1:0] act,
                                       logic [VALUE_BITS-1:0] val,
                                       logic [POSITION_BITS-1:0] pos,
                                       logic typed, logic ok,
                                       logic [VALUE_BITS-1:0] vout,
                                       logic [ENTRY_BITS-1:0] cnt);
        script_row_t row;
        row.req.action      = act;
        row.req.item_value  = val;
        row.req.position    = pos;
        row.typed           = typed;
        row.want.ok         = ok;
        row.want.value_out  = vout;
        row.want.entry_count = cnt;
        return row;
    endfunction

    function automatic in_item_t pick_request(int ins_pct);
        in_item_t pick;
        int       roll;
        int       n;
        n    = held.size();
        roll = $urandom_range(99);
        pick.item_value = $urandom();
        pick.position   = POSITION_BITS'($urandom_range(15));
        if (roll < 3)
            pick.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
        else if (roll < 3 + ins_pct)
            pick.action = $urandom_range(1) ? ACT_APPEND : ACT_PREPEND;
        else
        begin
            case ($urandom_range(3))
                0: pick.action = ACT_READ_POS;
                1: pick.action = ACT_REMOVE_VAL;
                2: pick.action = ACT_REMOVE_POS;
                default: pick.action = ACT_CONTAINS;
            endcase
        end
        if ($urandom_range(99) < 60)
        begin
            if (n > 0 && $urandom_range(1))
                pick.item_value = held[$urandom_range(n - 1)];
            else
                pick.item_value = pool[$urandom_range(POOL_SIZE - 1)];
        end
        if (n > 0 && $urandom_range(99) < 75)
            pick.position = POSITION_BITS'($urandom_range(n - 1));
        return pick;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic note_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%0t: %s: expected ok=%0b value=%08h count=%0d, %s",
                     $time, what, want.ok, want.value_out, want.entry_count,
                     $sformatf("got ok=%0b value=%08h count=%0d",
                               got.ok, got.value_out, got.entry_count));
    endtask

    task automatic drive_item(in_item_t req, logic typed, out_item_t want);
        out_item_t got;
        int        gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        got = apply_request(req);
        if (typed)
            got = want;
        pending_results.push_back(got);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_now = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off while the sender keeps going
    initial
    begin : receiver
        int run;
        int roll;
        run = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0 && !quiet)
            begin
                roll = $urandom_range(99);
                if (roll >= 95)
                    run = $urandom_range(40, 10);
                else if (roll >= 70)
                    run = $urandom_range(3, 1);
            end
            out_stall <= hold_on || run > 0;
            if (run > 0)
                run--;
        end
    end

    initial
    begin : pressure
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", '0, out_item);
            else
            begin
                want_now = pending_results.pop_front();
                if (out_item.ok !== want_now.ok
                    || out_item.value_out !== want_now.value_out
                    || out_item.entry_count !== want_now.entry_count)
                    note_mismatch("result mismatch", want_now, out_item);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : main
        int        ph;
        int        k;
        int        ins_pct;
        in_item_t  req;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        cap_now    = CAP_RESET;
        mismatches = 0;
        quiet      = 1'b0;
        hold_go    = 1'b0;
        pool[0] = '0;
        pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            pool[k] = $urandom();

        script.push_back(mk(ACT_READ_POS,   32'h0,        4'd0,  1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_REMOVE_POS, 32'h0,        4'd0,  1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_REMOVE_VAL, 32'h0,        4'd0,  1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_CONTAINS,   32'h0,        4'd0,  1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_SPARE_A,    32'hFFFFFFFF, 4'd15, 1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_SPARE_B,    32'h0,        4'd0,  1'b1, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_APPEND,     32'hFFFFFFFF, 4'd0,  1'b1, 1'b1, 32'h0, 5'd1));
        script.push_back(mk(ACT_PREPEND,    32'h0,        4'd15, 1'b1, 1'b1, 32'h0, 5'd2));
        script.push_back(mk(ACT_READ_POS,   32'h0,        4'd0,  1'b1, 1'b1, 32'h0, 5'd2));
        script.push_back(mk(ACT_READ_POS,   32'h0,        4'd1,  1'b1, 1'b1, 32'hFFFFFFFF,
                            5'd2));
        script.push_back(mk(ACT_READ_POS,   32'h0,        4'd15, 1'b1, 1'b0, 32'h0, 5'd2));
        script.push_back(mk(ACT_CONTAINS,   32'hFFFFFFFF, 4'd0,  1'b1, 1'b1, 32'h0, 5'd2));
        script.push_back(mk(ACT_REMOVE_VAL, 32'h12345678, 4'd0,  1'b1, 1'b0, 32'h0, 5'd2));
        script.push_back(mk(ACT_APPEND,     32'hA5A5A5A5, 4'd0,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_PREPEND,    32'hA5A5A5A5, 4'd0,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_REMOVE_VAL, 32'hA5A5A5A5, 4'd0,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_READ_POS,   32'h0,        4'd2,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_REMOVE_POS, 32'h0,        4'd2,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_APPEND,     32'h5A5A5A5A, 4'd0,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_REMOVE_POS, 32'h0,        4'd0,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_SPARE_A,    32'h5A5A5A5A, 4'd1,  1'b0, 1'b0, 32'h0, 5'd0));
        script.push_back(mk(ACT_CONTAINS,   32'h5A5A5A5A, 4'd0,  1'b0, 1'b0, 32'h0, 5'd0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[k])
            drive_item(script[k].req, script[k].typed, script[k].want);
        in_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_capacity(5'd0);
                1: write_capacity(5'd1);
                2: write_capacity(5'd31);
                3: write_capacity(5'd5);
                4: write_capacity(5'd17);
                5: write_capacity(CAP_BITS'($urandom_range(31)));
                6: write_capacity(5'd2);
                default: write_capacity(CAP_RESET);
            endcase
            quiet = (ph == 4);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 2 && k == 10)
                    hold_go = 1'b1;
                ins_pct = ((k / BURST_ITEMS) % 2 == 0) ? 75 : 15;
                req = pick_request(ins_pct);
                drive_item(req, 1'b0, '0);
            end
            in_valid <= 1'b0;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bol_pkg.sv
hw/rtl/bol_ram.sv
hw/rtl/bol_free_map.sv
hw/rtl/bounded_ordered_list_engine_unit.sv
bench/bounded_ordered_list_engine_unit_tb.sv
